[hw/rtl/ssdcs_pkg.sv]
`default_nettype none

package ssdcs_pkg;

    localparam int DIGIT_COUNT_DEF = 4;

    // frame bytes
    localparam logic [7:0] BYTE_SETTINGS = 8'h80;
    localparam logic [7:0] BYTE_MODE_ALL = 8'h40;
    localparam logic [7:0] BYTE_MODE_ONE = 8'h44;
    localparam logic [7:0] BYTE_ADDR_ALL = 8'hC0;
    localparam logic [7:0] BYTE_ADDR_ONE = 8'hC1;
    localparam logic [7:0] DIGIT_MASK    = 8'h7F;

    typedef enum logic [2:0] {
        ACT_CONFIGURE  = 3'd0,
        ACT_BRIGHTNESS = 3'd1,
        ACT_ON         = 3'd2,
        ACT_OFF        = 3'd3,
        ACT_SET_DOT    = 3'd4,
        ACT_TOGGLE_DOT = 3'd5,
        ACT_SET_DIGIT  = 3'd6,
        ACT_REFRESH    = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BYTE  = 2'd1,
        SYM_STOP  = 2'd2
    } t_sym;

    typedef enum logic [2:0] {
        BS_NONE,
        BS_SETTINGS,
        BS_MODE_ALL,
        BS_MODE_ONE,
        BS_ADDR_ALL,
        BS_ADDR_ONE,
        BS_DIGIT
    } t_byte_sel;

    // which frames a command runs through
    typedef enum logic [1:0] {
        SEQ_SET,
        SEQ_CFG,
        SEQ_FULL,
        SEQ_DOT
    } t_seq;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEAD_STOP,
        ST_SET_START,
        ST_SET_BYTE,
        ST_SET_STOP,
        ST_MODE_START,
        ST_MODE_BYTE,
        ST_MODE_STOP,
        ST_ADDR_START,
        ST_ADDR_BYTE,
        ST_DIGIT,
        ST_END_STOP
    } t_state;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_sym      kind;
        t_byte_sel sel;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        logic bri_chg;
        logic on_chg;
        logic off_chg;
        logic dot_chg;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/ssdcs_dp.sv]
`default_nettype none

module ssdcs_dp #(
    parameter int DIGIT_COUNT = ssdcs_pkg::DIGIT_COUNT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ssdcs_pkg::t_action             i_action,
    input  wire  [6:0]                     i_value,
    input  wire  [1:0]                     i_digit,
    input  ssdcs_pkg::t_dp_cmd             i_cmd,
    input  wire  [$clog2(DIGIT_COUNT)-1:0] i_digit_idx,
    output ssdcs_pkg::t_dp_stat            o_stat,
    input  wire                            i_m_tready,
    output logic                           o_m_tvalid,
    output logic [7:0]                     o_m_tdata,
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);
    import ssdcs_pkg::*;

    localparam int DW = $clog2(DIGIT_COUNT);

    logic       r_en;
    logic [2:0] r_bri;
    logic       r_dot;
    logic [6:0] r_pat [DIGIT_COUNT];

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_sym       r_out_kind;
    logic       r_out_last;

    logic       dot_want;
    logic [7:0] sym_byte;

    assign dot_want = (i_action == ACT_SET_DOT) ? i_value[0] : ~r_dot;

    always_comb begin
        o_stat.bri_chg  = (i_value[2:0] != r_bri);
        o_stat.on_chg   = ~r_en;
        o_stat.off_chg  = r_en;
        o_stat.dot_chg  = (dot_want != r_dot);
        o_stat.out_free = ~r_out_valid | i_m_tready;
    end

    always_comb begin
        case (i_cmd.sel)
            BS_SETTINGS: sym_byte = BYTE_SETTINGS | {4'b0000, r_en, r_bri};
            BS_MODE_ALL: sym_byte = BYTE_MODE_ALL;
            BS_MODE_ONE: sym_byte = BYTE_MODE_ONE;
            BS_ADDR_ALL: sym_byte = BYTE_ADDR_ALL;
            BS_ADDR_ONE: sym_byte = BYTE_ADDR_ONE;
            BS_DIGIT: begin
                if (i_digit_idx == DW'(1)) begin
                    sym_byte = {r_dot, r_pat[1]};
                end else begin
                    sym_byte = {1'b0, r_pat[i_digit_idx]} & DIGIT_MASK;
                end
            end
            default: sym_byte = 8'h00;
        endcase
    end

    // display state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_bri <= 3'd7;
            r_dot <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_pat[i] <= 7'd0;
            end
        end else if (i_cmd.load) begin
            unique case (i_action)
                ACT_BRIGHTNESS: begin
                    r_bri <= i_value[2:0];
                    if (o_stat.bri_chg) begin
                        r_en <= 1'b1;
                    end
                end
                ACT_ON:                     r_en  <= 1'b1;
                ACT_OFF:                    r_en  <= 1'b0;
                ACT_SET_DOT, ACT_TOGGLE_DOT: r_dot <= dot_want;
                ACT_SET_DIGIT: begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (int'(i_digit) == i) begin
                            r_pat[i] <= i_value;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= sym_byte;
            r_out_kind <= i_cmd.kind;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

[hw/rtl/ssdcs_ctrl.sv]
`default_nettype none

module ssdcs_ctrl #(
    parameter int DIGIT_COUNT = ssdcs_pkg::DIGIT_COUNT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    input  ssdcs_pkg::t_action             i_action,
    input  ssdcs_pkg::t_dp_stat            i_stat,
    output logic                           o_s_tready,
    output ssdcs_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(DIGIT_COUNT)-1:0] o_digit_idx
);
    import ssdcs_pkg::*;

    localparam int DW = $clog2(DIGIT_COUNT);

    t_state        r_state, n_state;
    t_seq          r_seq, n_seq;
    logic [DW-1:0] r_digit, n_digit;

    always_comb begin
        n_state = r_state;
        n_seq   = r_seq;
        n_digit = r_digit;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (i_action)
                        ACT_CONFIGURE: begin
                            n_state = ST_LEAD_STOP;
                            n_seq   = SEQ_CFG;
                        end
                        ACT_BRIGHTNESS: begin
                            if (i_stat.bri_chg) begin
                                n_state = ST_SET_START;
                                n_seq   = SEQ_SET;
                            end
                        end
                        ACT_ON: begin
                            if (i_stat.on_chg) begin
                                n_state = ST_SET_START;
                                n_seq   = SEQ_SET;
                            end
                        end
                        ACT_OFF: begin
                            if (i_stat.off_chg) begin
                                n_state = ST_SET_START;
                                n_seq   = SEQ_SET;
                            end
                        end
                        ACT_SET_DOT, ACT_TOGGLE_DOT: begin
                            if (i_stat.dot_chg) begin
                                n_state = ST_MODE_START;
                                n_seq   = SEQ_DOT;
                            end
                        end
                        ACT_REFRESH: begin
                            n_state = ST_MODE_START;
                            n_seq   = SEQ_FULL;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                if (i_stat.out_free) begin
                    unique case (r_state)
                        ST_LEAD_STOP:  n_state = ST_SET_START;
                        ST_SET_START:  n_state = ST_SET_BYTE;
                        ST_SET_BYTE:   n_state = ST_SET_STOP;
                        ST_SET_STOP:   n_state = (r_seq == SEQ_CFG) ? ST_MODE_START : ST_IDLE;
                        ST_MODE_START: n_state = ST_MODE_BYTE;
                        ST_MODE_BYTE:  n_state = ST_MODE_STOP;
                        ST_MODE_STOP:  n_state = ST_ADDR_START;
                        ST_ADDR_START: n_state = ST_ADDR_BYTE;
                        ST_ADDR_BYTE: begin
                            n_state = ST_DIGIT;
                            n_digit = (r_seq == SEQ_DOT) ? DW'(1) : '0;
                        end
                        ST_DIGIT: begin
                            if (r_seq == SEQ_DOT || r_digit == DW'(DIGIT_COUNT - 1)) begin
                                n_state = ST_END_STOP;
                            end else begin
                                n_digit = r_digit + DW'(1);
                            end
                        end
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.kind = SYM_START;
        o_cmd.sel  = BS_NONE;
        o_cmd.last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_LEAD_STOP: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_STOP;
            end
            ST_SET_START, ST_MODE_START, ST_ADDR_START: begin
                o_cmd.emit = i_stat.out_free;
            end
            ST_SET_BYTE: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_BYTE;
                o_cmd.sel  = BS_SETTINGS;
            end
            ST_SET_STOP: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_STOP;
                o_cmd.last = (r_seq == SEQ_SET);
            end
            ST_MODE_BYTE: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_BYTE;
                o_cmd.sel  = (r_seq == SEQ_DOT) ? BS_MODE_ONE : BS_MODE_ALL;
            end
            ST_MODE_STOP: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_STOP;
            end
            ST_ADDR_BYTE: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_BYTE;
                o_cmd.sel  = (r_seq == SEQ_DOT) ? BS_ADDR_ONE : BS_ADDR_ALL;
            end
            ST_DIGIT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_BYTE;
                o_cmd.sel  = BS_DIGIT;
            end
            ST_END_STOP: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = SYM_STOP;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_digit_idx = r_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seq   <= SEQ_SET;
            r_digit <= '0;
        end else begin
            r_state <= n_state;
            r_seq   <= n_seq;
            r_digit <= n_digit;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/seven_segment_display_command_sequencer.sv]
`default_nettype none

// Channel   Dir  tdata (low bit up)              tuser             tlast
// s_*       in   value[6:0], digit[8:7], 0 pad   action[2:0]       -
// m_*       out  bus_byte[7:0]                   symbol_kind[1:0]  last symbol of command
//
// One command at a time: accepted only while the sequencer is idle, then one
// bus symbol per cycle from the frame sequencer while m_tready does not stall it.
// Configure emits 10 + DIGIT_COUNT symbols, refresh 6 + DIGIT_COUNT, a dot
// change 7, a settings change 3, and a command that changes nothing none.
// Synchronous active-low reset: display off, brightness 7, dot clear, digits blank.
// A stalled m_tready holds the output register and freezes the sequencer.
module seven_segment_display_command_sequencer #(
    parameter int DIGIT_COUNT = ssdcs_pkg::DIGIT_COUNT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command input
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [6:0] value, [8:7] digit, [15:9] zero
    input  wire  [2:0]  i_s_tuser,   // [2:0] action
    // bus symbol output
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] bus_byte
    output logic [1:0]  o_m_tuser,   // [1:0] symbol_kind
    output logic        o_m_tlast
);
    import ssdcs_pkg::*;

    localparam int DW = $clog2(DIGIT_COUNT);

    t_action       action;
    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [DW-1:0] digit_idx;

    assign action = t_action'(i_s_tuser);

    // frame sequencer
    ssdcs_ctrl #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_action    (action),
        .i_stat      (stat),
        .o_s_tready  (o_s_tready),
        .o_cmd       (cmd),
        .o_digit_idx (digit_idx)
    );

    // display state, byte build and output register
    ssdcs_dp #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (action),
        .i_value     (i_s_tdata[6:0]),
        .i_digit     (i_s_tdata[8:7]),
        .i_cmd       (cmd),
        .i_digit_idx (digit_idx),
        .o_stat      (stat),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

`ifndef SYNTHESIS
    // a command always ends on a stop condition
    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == SYM_STOP))
        else $error("last symbol is not a stop");

    // start and stop carry no byte
    a_ctrl_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != SYM_BYTE)) |-> (o_m_tdata == 8'h00))
        else $error("nonzero byte on start or stop");

    // set digit emits nothing and leaves the sequencer idle
    a_set_digit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (action == ACT_SET_DIGIT)) |=> o_s_tready)
        else $error("set digit started a frame");

    // a symbol is only loaded when the output slot is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_m_tvalid || i_m_tready))
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

// Testbench for the seven-segment command sequencer.
//
// Commands go in on the s_* stream (action in tuser, value/digit in tdata),
// bus symbols come out on the m_* stream (kind in tuser, byte in tdata,
// tlast on the final symbol of a command). A behavioral model of the
// display state runs alongside the DUT. Each accepted command appends its
// expected symbols to a queue. The output monitor pops one entry per
// output transfer and compares kind, byte and last.
//
// Sequence: directed commands first (extremes, every action, no-op cases),
// then three random phases with different stall profiles on each side.
module tb;
    import ssdcs_pkg::*;

    localparam int DIGIT_COUNT = DIGIT_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer
    localparam int DRAIN_HOLD  = 20;    // longest command is 14 symbols
    localparam int MAX_REPORTS = 10;

    // one expected bus symbol
    typedef struct {
        t_sym       kind;
        logic [7:0] bus_byte;
        logic       last;
    } t_bus_sym;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // [6:0] value, [8:7] digit, [15:9] zero
    logic [2:0]  i_s_tuser = '0;   // [2:0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // [7:0] bus_byte
    logic [1:0]  o_m_tuser;        // [1:0] symbol_kind
    logic        o_m_tlast;

    // model copy of the display state (reset values)
    logic       disp_on = 1'b0;
    logic [2:0] bright_lvl = 3'd7;
    logic       dot_on = 1'b0;
    logic [6:0] digit_pat [DIGIT_COUNT];

    t_bus_sym syms_due [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;
    int cmds_sent = 0;
    int syms_checked = 0;
    int idle_cycles = 0;

    seven_segment_display_command_sequencer #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // ---------------------------------------------------------------
    // Expected-symbol builder
    // ---------------------------------------------------------------
    function automatic void push_sym(t_sym kind, logic [7:0] b);
        t_bus_sym s;
        s.kind     = kind;
        s.bus_byte = b;
        s.last     = 1'b0;
        syms_due.push_back(s);
    endfunction

    // start, one byte, stop
    function automatic void push_frame(logic [7:0] b);
        push_sym(SYM_START, 8'h00);
        push_sym(SYM_BYTE, b);
        push_sym(SYM_STOP, 8'h00);
    endfunction

    // digit 1 carries the dot in bit 7
    function automatic logic [7:0] digit_one_byte();
        return {dot_on, digit_pat[1]};
    endfunction

    function automatic void push_settings();
        push_frame(BYTE_SETTINGS | {4'b0, disp_on, bright_lvl});
    endfunction

    function automatic void push_full_write();
        push_frame(BYTE_MODE_ALL);
        push_sym(SYM_START, 8'h00);
        push_sym(SYM_BYTE, BYTE_ADDR_ALL);
        for (int i = 0; i < DIGIT_COUNT; i++)
            push_sym(SYM_BYTE, (i == 1) ? digit_one_byte() : {1'b0, digit_pat[i]});
        push_sym(SYM_STOP, 8'h00);
    endfunction

    // dot write goes to address 1 only; unchanged dot emits nothing
    function automatic void change_dot(logic want);
        if (want != dot_on) begin
            dot_on = want;
            push_frame(BYTE_MODE_ONE);
            push_sym(SYM_START, 8'h00);
            push_sym(SYM_BYTE, BYTE_ADDR_ONE);
            push_sym(SYM_BYTE, digit_one_byte());
            push_sym(SYM_STOP, 8'h00);
        end
    endfunction

    // Update the model for one command and queue the symbols it causes.
    function automatic void predict_symbols(t_action act, logic [6:0] val, logic [1:0] dig);
        int n0;
        n0 = syms_due.size();
        case (act)
            ACT_CONFIGURE: begin
                push_sym(SYM_STOP, 8'h00);
                push_settings();
                push_full_write();
            end
            ACT_BRIGHTNESS: begin
                // a new level also switches the display on
                if (val[2:0] != bright_lvl) begin
                    bright_lvl = val[2:0];
                    disp_on    = 1'b1;
                    push_settings();
                end
            end
            ACT_ON: begin
                if (!disp_on) begin
                    disp_on = 1'b1;
                    push_settings();
                end
            end
            ACT_OFF: begin
                if (disp_on) begin
                    disp_on = 1'b0;
                    push_settings();
                end
            end
            ACT_SET_DOT:    change_dot(val[0]);
            ACT_TOGGLE_DOT: change_dot(~dot_on);
            ACT_SET_DIGIT: begin
                // silent store; positions past the digit count are dropped
                if (int'(dig) < DIGIT_COUNT)
                    digit_pat[dig] = val;
            end
            ACT_REFRESH:    push_full_write();
            default: ;
        endcase
        if (syms_due.size() > n0)
            syms_due[syms_due.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Command driver: random gap, then hold tvalid until the transfer.
    // tvalid stays high between back-to-back commands.
    // ---------------------------------------------------------------
    task automatic send_cmd(input t_action act, input logic [6:0] val, input logic [1:0] dig);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, dig, val};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        predict_symbols(act, val, dig);
        cmds_sent++;
    endtask

    task automatic run_random_cmds(input int n);
        t_action act;
        for (int i = 0; i < n; i++) begin
            act = t_action'($urandom_range(7));
            // extra digit writes so refreshes show varied patterns
            if ($urandom_range(99) < 20)
                act = ACT_SET_DIGIT;
            send_cmd(act, 7'($urandom_range(127)), 2'($urandom_range(3)));
        end
    endtask

    // ---------------------------------------------------------------
    // Test tasks
    // ---------------------------------------------------------------
    task automatic test_directed_cmds();
        tx_idle_pct = 18;
        rx_idle_pct = 71;
        send_cmd(ACT_REFRESH,    7'h00, 2'd0);   // blank digits after reset
        send_cmd(ACT_SET_DIGIT,  7'h7F, 2'd0);
        send_cmd(ACT_SET_DIGIT,  7'h55, 2'd1);
        send_cmd(ACT_SET_DIGIT,  7'h2A, 2'd2);
        send_cmd(ACT_SET_DIGIT,  7'h00, 2'd3);
        send_cmd(ACT_CONFIGURE,  7'h00, 2'd0);
        send_cmd(ACT_BRIGHTNESS, 7'h7F, 2'd3);   // same level: no output
        send_cmd(ACT_BRIGHTNESS, 7'h78, 2'd0);   // level 0, display comes on
        send_cmd(ACT_ON,         7'h00, 2'd0);   // already on: no output
        send_cmd(ACT_OFF,        7'h00, 2'd0);
        send_cmd(ACT_OFF,        7'h7F, 2'd3);   // already off: no output
        send_cmd(ACT_ON,         7'h7F, 2'd3);
        send_cmd(ACT_SET_DOT,    7'h7E, 2'd0);   // dot already clear
        send_cmd(ACT_SET_DOT,    7'h7F, 2'd0);
        send_cmd(ACT_SET_DOT,    7'h01, 2'd0);   // dot already set
        send_cmd(ACT_TOGGLE_DOT, 7'h00, 2'd0);
        send_cmd(ACT_TOGGLE_DOT, 7'h7F, 2'd3);
        send_cmd(ACT_SET_DIGIT,  7'h7F, 2'd1);   // dot must stay in bit 7
        send_cmd(ACT_REFRESH,    7'h7F, 2'd3);
        send_cmd(ACT_BRIGHTNESS, 7'h05, 2'd0);
        send_cmd(ACT_CONFIGURE,  7'h7F, 2'd3);   // value/digit ignored
        send_cmd(ACT_SET_DIGIT,  7'h7F, 2'd3);
    endtask

    task automatic test_receiver_backpressure();
        tx_idle_pct = 18;
        rx_idle_pct = 71;
        run_random_cmds(63);
    endtask

    task automatic test_sender_gaps();
        tx_idle_pct = 71;
        rx_idle_pct = 18;
        run_random_cmds(63);
    endtask

    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_cmds(63);
    endtask

    // ---------------------------------------------------------------
    // Output side: random tready, and the symbol checker
    // ---------------------------------------------------------------
    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic note_mismatch(input string what, input t_bus_sym e);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: exp kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                     $realtime, what, e.kind, e.bus_byte, e.last,
                     o_m_tuser, o_m_tdata, o_m_tlast);
    endtask

    always @(posedge i_clk) begin : sym_check
        t_bus_sym e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            syms_checked++;
            if (syms_due.size() == 0) begin
                e = '{SYM_START, 8'h00, 1'b0};
                note_mismatch("symbol with nothing expected", e);
            end else begin
                e = syms_due.pop_front();
                if (o_m_tuser !== e.kind || o_m_tdata !== e.bus_byte || o_m_tlast !== e.last)
                    note_mismatch("symbol mismatch", e);
            end
        end
    end

    // watchdog: any transfer on either side resets the count
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d symbols pending",
                     STALL_LIMIT, syms_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        for (int i = 0; i < DIGIT_COUNT; i++)
            digit_pat[i] = 7'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cmds();
        test_receiver_backpressure();
        test_sender_gaps();
        test_full_rate();

        // all commands in; let the output side empty out
        i_s_tvalid <= 1'b0;
        while (syms_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);

        $display("Sent %0d commands (all actions, no-op cases, three stall profiles)",
                 cmds_sent);
        $display("Checked %0d bus symbols, %0d mismatches, %0d still expected",
                 syms_checked, mismatches, syms_due.size());
        if (mismatches == 0 && syms_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
